[src/sar_pkg.sv]
// Shared types and constants for the shelf atlas allocator.
// Used by sar_fit and shelf_atlas_allocator; depends on nothing.
`default_nettype none

package sar_pkg;

    // Defaults for the top-level parameters.
    localparam int PAGE_WIDTH_DEF  = 256;
    localparam int PAGE_HEIGHT_DEF = 256;
    localparam int ROW_STEP_DEF    = 4;
    localparam int MAX_PAGES_DEF   = 16;

    // Port widths of the request and result fields.
    localparam int RECT_W  = 12;
    localparam int PAGE_OW = 4;
    localparam int POSX_W  = 8;
    localparam int GEN_W   = 16;

    // Page sizes never exceed 256, so 9 bits hold any width, height or row.
    localparam int DIM_W = 9;

    // Reciprocal divide of a 9-bit value by a step of at most 16.
    localparam int DIV_SHIFT = 13;
    localparam int RECIP_W   = 14;

    // Request codes on the action input.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_SHELF = 5'b00100,
        S_SCAN  = 5'b01000,
        S_PICK  = 5'b10000
    } state_t;

    // Control from the sequencer to the best-fit compare unit.
    typedef struct packed {
        logic init;
        logic valid;
    } fit_ctl_t;

endpackage

`default_nettype wire

[src/sar_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module sar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[src/sar_fit.sv]
// Best-fit compare unit: tracks the page with the least free height that still fits.
// Depends on sar_pkg for the control struct and dimension width.
`default_nettype none

module sar_fit #(
    parameter int PAGE_AW = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sar_pkg::fit_ctl_t        ctl,
    input  wire logic [PAGE_AW-1:0]       page,
    input  wire logic [sar_pkg::DIM_W-1:0] free_height,
    input  wire logic [sar_pkg::DIM_W-1:0] need,
    output logic                          found,
    output logic [PAGE_AW-1:0]            best,
    output logic [sar_pkg::DIM_W-1:0]     best_free
);

    logic                      found_reg, found_next;
    logic [PAGE_AW-1:0]        best_reg, best_next;
    logic [sar_pkg::DIM_W-1:0] best_free_reg, best_free_next;
    logic                      take;

    // Later pages win ties, so the compare is less-or-equal.
    assign take = ctl.valid && (free_height >= need)
                  && (!found_reg || (free_height <= best_free_reg));

    always_comb
    begin
        found_next     = found_reg;
        best_next      = best_reg;
        best_free_next = best_free_reg;
        if (ctl.init)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next     = 1'b1;
            best_next      = page;
            best_free_next = free_height;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_free_reg <= best_free_next;
    end

    assign found     = found_reg;
    assign best      = best_reg;
    assign best_free = best_free_reg;

endmodule

`default_nettype wire

[src/shelf_atlas_allocator.sv]
// Shelf-packing atlas allocator. A clear gives its result in the cycle after the transfer.
// An allocate that fits its open shelf passes through S_DIV and S_SHELF before its result;
// one that opens a shelf passes through S_DIV, S_SHELF, S_SCAN and S_PICK, as the best-fit
// scan reads one page entry per cycle from the page RAM, one for each open page. busy is
// high until the result cycle, which overlaps the next transfer; the receiver cannot stall.
// Reset clears all shelf valid bits, the page count and the generation count.
`default_nettype none

module shelf_atlas_allocator #(
    parameter int PAGE_WIDTH  = sar_pkg::PAGE_WIDTH_DEF,
    parameter int PAGE_HEIGHT = sar_pkg::PAGE_HEIGHT_DEF,
    parameter int ROW_STEP    = sar_pkg::ROW_STEP_DEF,
    parameter int MAX_PAGES   = sar_pkg::MAX_PAGES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        action,
    input  wire logic [sar_pkg::RECT_W-1:0]  rect_width,
    input  wire logic [sar_pkg::RECT_W-1:0]  rect_height,
    output logic                             done,
    output logic                             ok,
    output logic [sar_pkg::PAGE_OW-1:0]      page_index,
    output logic [sar_pkg::POSX_W-1:0]       pos_x,
    output logic [sar_pkg::DIM_W-1:0]        pos_y,
    output logic [sar_pkg::GEN_W-1:0]        generation
);

    localparam int SHELF_COUNT = PAGE_HEIGHT / ROW_STEP + 1;
    localparam int SHELF_AW    = $clog2(SHELF_COUNT);
    localparam int PAGE_AW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W      = $clog2(MAX_PAGES + 1);
    localparam int DW          = sar_pkg::DIM_W;
    localparam int SHELF_DW    = PAGE_AW + 2 * DW;
    localparam int RECIP       = ((2 ** sar_pkg::DIV_SHIFT) + ROW_STEP - 1) / ROW_STEP;
    localparam int MUL_W       = DW + sar_pkg::RECIP_W;

    localparam logic [DW-1:0]     PW_C   = DW'(PAGE_WIDTH);
    localparam logic [DW-1:0]     PH_C   = DW'(PAGE_HEIGHT);
    localparam logic [PCNT_W-1:0] MAXP_C = PCNT_W'(MAX_PAGES);

    sar_pkg::state_t state_reg, state_next;

    logic [SHELF_COUNT-1:0]     valid_reg, valid_next;
    logic [PCNT_W-1:0]          pages_used_reg, pages_used_next;
    logic [sar_pkg::GEN_W-1:0]  clear_count_reg, clear_count_next;
    logic [DW-1:0]              w_reg, w_next;
    logic [DW-1:0]              v_reg, v_next;
    logic [SHELF_AW-1:0]        idx_reg, idx_next;
    logic [DW-1:0]              sh_reg, sh_next;
    logic [PCNT_W-1:0]          scan_reg, scan_next;
    logic                       pend_reg, pend_next;
    logic [PAGE_AW-1:0]         pend_page_reg, pend_page_next;

    logic                       done_reg, done_next;
    logic                       ok_reg, ok_next;
    logic [sar_pkg::PAGE_OW-1:0] page_reg, page_next;
    logic [sar_pkg::POSX_W-1:0] x_reg, x_next;
    logic [DW-1:0]              y_reg, y_next;
    logic [sar_pkg::GEN_W-1:0]  gen_reg, gen_next;

    // Datapath signals
    logic [sar_pkg::RECT_W:0]   h_sum;
    logic [MUL_W-1:0]           div_prod;
    logic [SHELF_AW-1:0]        idx_calc;

    logic                       shelf_we, shelf_re;
    logic [SHELF_DW-1:0]        shelf_wdata, shelf_rdata;
    logic [PAGE_AW-1:0]         rd_page;
    logic [DW-1:0]              rd_free, rd_row, hit_free;
    logic                       hit;

    logic                       page_we, page_re;
    logic [PAGE_AW-1:0]         page_waddr;
    logic [DW-1:0]              page_wdata, page_rdata;
    logic                       issue;

    sar_pkg::fit_ctl_t          fit_ctl;
    logic                       fit_found;
    logic [PAGE_AW-1:0]         fit_best, new_page;
    logic [DW-1:0]              fit_best_free, base_free, new_free, fresh_free;

    assign h_sum    = {1'b0, rect_height} + (sar_pkg::RECT_W + 1)'(ROW_STEP - 1);
    // Divide by the row step through a reciprocal; exact for every 9-bit value.
    assign div_prod = MUL_W'(v_reg) * MUL_W'(RECIP);
    assign idx_calc = div_prod[sar_pkg::DIV_SHIFT +: SHELF_AW];

    assign {rd_page, rd_free, rd_row} = shelf_rdata;
    assign hit      = valid_reg[idx_reg] && (rd_free >= w_reg);
    assign hit_free = rd_free - w_reg;

    assign issue      = state_reg == sar_pkg::S_SCAN && scan_reg < pages_used_reg;
    assign new_page   = fit_found ? fit_best : pages_used_reg[PAGE_AW-1:0];
    assign base_free  = fit_found ? fit_best_free : PH_C;
    assign new_free   = base_free - sh_reg;
    assign fresh_free = PW_C - w_reg;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        pages_used_next  = pages_used_reg;
        clear_count_next = clear_count_reg;
        w_next           = w_reg;
        v_next           = v_reg;
        idx_next         = idx_reg;
        sh_next          = sh_reg;
        scan_next        = scan_reg;
        pend_next        = 1'b0;
        pend_page_next   = pend_page_reg;
        done_next        = 1'b0;
        ok_next          = ok_reg;
        page_next        = page_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        gen_next         = gen_reg;
        shelf_we         = 1'b0;
        shelf_re         = 1'b0;
        shelf_wdata      = {rd_page, hit_free, rd_row};
        page_we          = 1'b0;
        page_re          = 1'b0;
        page_waddr       = new_page;
        page_wdata       = new_free;
        fit_ctl.init     = 1'b0;
        fit_ctl.valid    = 1'b0;

        unique case (state_reg)
            sar_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (action == sar_pkg::ACT_CLEAR)
                    begin
                        valid_next       = '0;
                        pages_used_next  = '0;
                        clear_count_next = clear_count_reg + 1'b1;
                        done_next        = 1'b1;
                        ok_next          = 1'b1;
                        page_next        = '0;
                        x_next           = '0;
                        y_next           = '0;
                        gen_next         = clear_count_reg + 1'b1;
                    end
                    else
                    begin
                        w_next     = (rect_width > sar_pkg::RECT_W'(PAGE_WIDTH))
                                     ? PW_C : rect_width[DW-1:0];
                        v_next     = (h_sum > (sar_pkg::RECT_W + 1)'(PAGE_HEIGHT))
                                     ? PH_C : h_sum[DW-1:0];
                        state_next = sar_pkg::S_DIV;
                    end
                end
            end
            sar_pkg::S_DIV:
            begin
                idx_next   = idx_calc;
                shelf_re   = 1'b1;
                state_next = sar_pkg::S_SHELF;
            end
            sar_pkg::S_SHELF:
            begin
                sh_next = DW'(idx_reg * ROW_STEP);
                if (hit)
                begin
                    shelf_we   = 1'b1;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    page_next  = sar_pkg::PAGE_OW'(rd_page);
                    x_next     = hit_free[sar_pkg::POSX_W-1:0];
                    y_next     = rd_row;
                    gen_next   = clear_count_reg;
                    state_next = sar_pkg::S_IDLE;
                end
                else
                begin
                    fit_ctl.init = 1'b1;
                    scan_next    = '0;
                    state_next   = sar_pkg::S_SCAN;
                end
            end
            sar_pkg::S_SCAN:
            begin
                // Read one page per cycle; the compare takes each read in the cycle after it.
                fit_ctl.valid = pend_reg;
                if (issue)
                begin
                    page_re        = 1'b1;
                    pend_next      = 1'b1;
                    pend_page_next = scan_reg[PAGE_AW-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = sar_pkg::S_PICK;
                end
            end
            sar_pkg::S_PICK:
            begin
                done_next  = 1'b1;
                gen_next   = clear_count_reg;
                state_next = sar_pkg::S_IDLE;
                if (!fit_found && pages_used_reg >= MAXP_C)
                begin
                    ok_next   = 1'b0;
                    page_next = '0;
                    x_next    = '0;
                    y_next    = '0;
                end
                else
                begin
                    page_we     = 1'b1;
                    shelf_we    = 1'b1;
                    shelf_wdata = {new_page, fresh_free, new_free};
                    valid_next[idx_reg] = 1'b1;
                    if (!fit_found)
                    begin
                        pages_used_next = pages_used_reg + 1'b1;
                    end
                    ok_next   = 1'b1;
                    page_next = sar_pkg::PAGE_OW'(new_page);
                    x_next    = fresh_free[sar_pkg::POSX_W-1:0];
                    y_next    = new_free;
                end
            end
            default:
            begin
                state_next = sar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sar_pkg::S_IDLE;
            valid_reg       <= '0;
            pages_used_reg  <= '0;
            clear_count_reg <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            pages_used_reg  <= pages_used_next;
            clear_count_reg <= clear_count_next;
            pend_reg        <= pend_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        v_reg         <= v_next;
        idx_reg       <= idx_next;
        sh_reg        <= sh_next;
        scan_reg      <= scan_next;
        pend_page_reg <= pend_page_next;
        ok_reg        <= ok_next;
        page_reg      <= page_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        gen_reg       <= gen_next;
    end

    sar_ram #(
        .WIDTH (SHELF_DW),
        .DEPTH (SHELF_COUNT)
    ) u_shelf_ram (
        .clk   (clk),
        .we    (shelf_we),
        .waddr (idx_reg),
        .wdata (shelf_wdata),
        .re    (shelf_re),
        .raddr (idx_calc),
        .rdata (shelf_rdata)
    );

    sar_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .re    (page_re),
        .raddr (scan_reg[PAGE_AW-1:0]),
        .rdata (page_rdata)
    );

    sar_fit #(
        .PAGE_AW (PAGE_AW)
    ) u_fit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (fit_ctl),
        .page        (pend_page_reg),
        .free_height (page_rdata),
        .need        (sh_reg),
        .found       (fit_found),
        .best        (fit_best),
        .best_free   (fit_best_free)
    );

    assign busy       = !state_reg[0];
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign page_index = page_reg;
    assign pos_x      = x_reg;
    assign pos_y      = y_reg;
    assign generation = gen_reg;

endmodule

`default_nettype wire
